/* hdl/umds_pkg.sv */
// Shared types and constants of the USB MIDI descriptor scanner.
package umds_pkg;

  // Configuration register indexes.
  localparam logic [7:0] REG_MATCH_CLASS    = 8'd0;
  localparam logic [7:0] REG_MATCH_SUBCLASS = 8'd1;

  // Register values after reset: audio class, MIDI streaming subclass.
  localparam logic [7:0] MATCH_CLASS_RST    = 8'h01;
  localparam logic [7:0] MATCH_SUBCLASS_RST = 8'h03;

  // Descriptor type codes and field values.
  localparam logic [7:0] DESC_TYPE_INTERFACE   = 8'h04;
  localparam logic [7:0] DESC_TYPE_ENDPOINT    = 8'h05;
  localparam logic [7:0] DESC_TYPE_CS_ENDPOINT = 8'h25;
  localparam logic [7:0] CS_SUBTYPE_GENERAL    = 8'h01;
  localparam logic [1:0] XFER_TYPE_BULK        = 2'b10;
  localparam int unsigned EP_DIR_IN_BIT        = 7;

  // Shortest descriptor that can match in each search mode.
  localparam logic [7:0] MIN_LEN_INTERFACE   = 8'd7;
  localparam logic [7:0] MIN_LEN_ENDPOINT    = 8'd6;
  localparam logic [7:0] MIN_LEN_CS_ENDPOINT = 8'd3;
  localparam logic [7:0] MIN_LEN_TYPED       = 8'd2;

  // Header byte offsets.
  localparam logic [15:0] OFS_TOTAL_LO   = 16'd2;
  localparam logic [15:0] OFS_TOTAL_HI   = 16'd3;
  localparam logic [15:0] OFS_CONFIG_VAL = 16'd5;
  localparam logic [15:0] OFS_HEADER_END = 16'd4;
  localparam logic [15:0] OFS_MAX        = 16'hFFFF;

  // Number of captured bytes after the length byte.
  localparam int unsigned CAPTURE_DEPTH = 6;

  typedef enum logic [1:0] {
    ST_SEARCHING = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NO_MATCH  = 2'd2,
    ST_MALFORMED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    MODE_FIND_IF   = 2'd0,
    MODE_FIND_EP   = 2'd1,
    MODE_CHECK_CS  = 2'd2,
    MODE_FOUND     = 2'd3
  } mode_e;

  // Scan state carried from one byte to the next.
  typedef struct packed {
    mode_e                            mode;
    logic [15:0]                      offset;
    logic [15:0]                      total;
    logic [7:0]                       pos;
    logic [7:0]                       dlen;
    logic [CAPTURE_DEPTH-1:0][7:0]    cap;
    logic [3:0]                       ep;
    logic [15:0]                      mps;
    logic [7:0]                       cfg_val;
    status_e                          status;
  } scan_state_t;

  // One result item.
  typedef struct packed {
    status_e     status;
    logic [3:0]  ep;
    logic [15:0] mps;
    logic [7:0]  cfg_val;
  } result_t;

endpackage

/* hdl/umds_walk.sv */
// Next-state logic of the descriptor walk for one accepted byte.
module umds_walk import umds_pkg::*; (
  input  scan_state_t state_i,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  input  logic [7:0]  match_class_i,
  input  logic [7:0]  match_subclass_i,
  output scan_state_t state_o,
  output result_t     result_o
);

  always_comb begin
    scan_state_t s;
    scan_state_t n;
    logic        ended;
    logic [2:0]  idx;
    logic        has_type;

    // A restart mark clears the scan before the byte is taken.
    s = first_byte_i ? '0 : state_i;
    n = s;
    idx = s.pos[2:0] - 3'd1;
    has_type = 1'b0;
    ended = (s.status == ST_NO_MATCH) || (s.status == ST_MALFORMED) ||
            ((s.offset >= OFS_HEADER_END) && (s.offset >= s.total));

    if (!ended) begin
      // Header fields.
      case (s.offset)
        OFS_TOTAL_LO:   n.total[7:0]  = data_byte_i;
        OFS_TOTAL_HI:   n.total[15:8] = data_byte_i;
        OFS_CONFIG_VAL: n.cfg_val     = data_byte_i;
        default:        ;
      endcase

      // Walk the descriptor by its length byte.
      if ((s.pos == 8'd0) && (data_byte_i == 8'd0)) begin
        n.status = ST_MALFORMED;
      end else begin
        if (s.pos == 8'd0) begin
          n.dlen = data_byte_i;
          n.cap  = '0;
        end else if (s.pos <= 8'(CAPTURE_DEPTH)) begin
          n.cap[idx] = data_byte_i;
        end

        if (({1'b0, s.pos} + 9'd1) >= {1'b0, n.dlen}) begin
          // Last byte of the descriptor: decide on it.
          has_type = n.dlen >= MIN_LEN_TYPED;
          unique case (s.mode)
            MODE_FIND_IF: begin
              if (has_type && n.cap[0] == DESC_TYPE_INTERFACE &&
                  n.dlen >= MIN_LEN_INTERFACE && n.cap[4] == match_class_i &&
                  n.cap[5] == match_subclass_i) begin
                n.mode = MODE_FIND_EP;
              end
            end
            MODE_FIND_EP: begin
              if (has_type && n.cap[0] == DESC_TYPE_ENDPOINT &&
                  n.dlen >= MIN_LEN_ENDPOINT && n.cap[1][EP_DIR_IN_BIT] &&
                  n.cap[2][3:0] == {2'b00, XFER_TYPE_BULK}) begin
                n.ep   = n.cap[1][3:0];
                n.mps  = {n.cap[4], n.cap[3]};
                n.mode = MODE_CHECK_CS;
              end
            end
            MODE_CHECK_CS: begin
              if (has_type && n.cap[0] == DESC_TYPE_CS_ENDPOINT &&
                  n.dlen >= MIN_LEN_CS_ENDPOINT && n.cap[1] == CS_SUBTYPE_GENERAL) begin
                n.mode   = MODE_FOUND;
                n.status = ST_FOUND;
              end else begin
                n.mode = MODE_FIND_EP;
              end
            end
            default: ;
          endcase
          n.pos = 8'd0;
        end else begin
          n.pos = s.pos + 8'd1;
        end
      end

      // Saturating byte offset.
      if (s.offset != OFS_MAX) begin
        n.offset = s.offset + 16'd1;
      end

      // End of the descriptor set.
      if (n.status != ST_NO_MATCH && n.status != ST_MALFORMED &&
          n.offset >= OFS_HEADER_END && n.offset >= n.total) begin
        n.status = (n.mode == MODE_FOUND) ? ST_FOUND : ST_NO_MATCH;
      end
    end

    state_o = n;
    result_o.status  = n.status;
    result_o.ep      = (n.status == ST_FOUND) ? n.ep  : 4'd0;
    result_o.mps     = (n.status == ST_FOUND) ? n.mps : 16'd0;
    result_o.cfg_val = n.cfg_val;
  end

endmodule

/* hdl/umds_out_stage.sv */
// Result register with valid and ready towards the receiver.
module umds_out_stage import umds_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  input  logic    out_ready_i,
  output logic    out_valid_o,
  output logic    free_o,
  output result_t result_o
);

  logic    valid_q, valid_d;
  result_t data_q;

  // The stage can take a new result when empty or when its result leaves now.
  assign free_o  = !valid_q || out_ready_i;
  assign valid_d = load_i ? 1'b1 : (valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = data_q;

endmodule

/* hdl/usb_midi_descriptor_scanner_top.sv */
// Top level of the USB MIDI descriptor scanner.
//
// The block takes a configuration descriptor set one byte per input
// transaction (data_byte_i, with first_byte_i marking byte zero of a new
// set) and returns one result transaction per byte: scan status, endpoint
// number and max packet size of the chosen bulk IN endpoint, and the
// configuration value from the header.
// The result of a byte accepted at one edge is valid after that edge.
// The block takes one byte per cycle while the result register can take a
// new result; the walk, the decision and the end check are one short step
// between the scan state registers and the result register.
// The receiver may stall: in_ready_o stays high while the result register
// is empty or its result is taken in the same cycle, and drops otherwise.
// Configuration writes (index 0 match class, index 1 match subclass) are
// always taken; other indexes are ignored.
// Reset clears the scan state, empties the result register and sets the
// match registers to audio class, MIDI streaming subclass.
module usb_midi_descriptor_scanner_top import umds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        first_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  scan_status_o,
  output logic [3:0]  endpoint_number_o,
  output logic [15:0] max_packet_size_o,
  output logic [7:0]  config_value_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  scan_state_t state_q, state_d;
  logic [7:0]  match_class_q, match_subclass_q;
  logic        accept;
  logic        free;
  result_t     result_d, result_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = free;
  assign accept      = in_valid_i && free;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_class_q    <= MATCH_CLASS_RST;
      match_subclass_q <= MATCH_SUBCLASS_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_MATCH_CLASS:    match_class_q    <= cfg_data_i;
        REG_MATCH_SUBCLASS: match_subclass_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Next scan state for the byte on the input.
  umds_walk u_walk (
    .state_i          (state_q),
    .data_byte_i      (data_byte_i),
    .first_byte_i     (first_byte_i),
    .match_class_i    (match_class_q),
    .match_subclass_i (match_subclass_q),
    .state_o          (state_d),
    .result_o         (result_d)
  );

  // Scan state registers, updated on each accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  umds_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .result_i    (result_d),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (free),
    .result_o    (result_q)
  );

  assign scan_status_o     = result_q.status;
  assign endpoint_number_o = result_q.ep;
  assign max_packet_size_o = result_q.mps;
  assign config_value_o    = result_q.cfg_val;

endmodule

/* hdl/umds_checker.sv */
// Port-level checks of the descriptor scanner, bound to the top level.
module umds_checker import umds_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [1:0]  scan_status_o,
  input logic [3:0]  endpoint_number_o,
  input logic [15:0] max_packet_size_o
);

  // An accepted byte always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("no result after an accepted byte");

  // An empty result register never holds back the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with an empty result register");

  // Endpoint fields are zero unless the scan has found a match.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scan_status_o != ST_FOUND |->
      endpoint_number_o == 4'd0 && max_packet_size_o == 16'd0)
    else $error("endpoint fields set without a match");

  // A stalled result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(scan_status_o))
    else $error("stalled result dropped or changed");

endmodule

bind usb_midi_descriptor_scanner_top umds_checker u_umds_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .scan_status_o     (scan_status_o),
  .endpoint_number_o (endpoint_number_o),
  .max_packet_size_o (max_packet_size_o)
);

/* verif/tb_usb_midi_descriptor_scanner_top.sv */
// Testbench of the USB MIDI descriptor scanner: predicts and checks every result transaction.
module tb_usb_midi_descriptor_scanner_top;
  import umds_pkg::*;

  // Kinds of descriptor that the stimulus builder can emit.
  localparam int KIND_HEADER = 0;
  localparam int KIND_IF     = 1;
  localparam int KIND_EP     = 2;
  localparam int KIND_CS     = 3;
  localparam int KIND_OTHER  = 4;

  localparam logic [7:0] DESC_TYPE_CONFIG = 8'h02;
  localparam int unsigned RANDOM_ITEMS    = 1750;

  // Scan predictor and the queue of results that it expects from the block.
  class scan_scoreboard;
    logic [7:0]  match_cls;
    logic [7:0]  match_sub;
    mode_e       mode;
    logic [15:0] offset;
    logic [15:0] total;
    logic [7:0]  pos;
    logic [7:0]  dlen;
    logic [7:0]  cap [CAPTURE_DEPTH];
    logic [3:0]  ep;
    logic [15:0] mps;
    logic [7:0]  cfg_val;
    status_e     status;
    result_t     pending_reports [$];
    int unsigned failures;

    function new();
      match_cls = MATCH_CLASS_RST;
      match_sub = MATCH_SUBCLASS_RST;
      failures  = 0;
      clear_scan();
    endfunction

    function void clear_scan();
      mode    = MODE_FIND_IF;
      offset  = '0;
      total   = '0;
      pos     = '0;
      dlen    = '0;
      ep      = '0;
      mps     = '0;
      cfg_val = '0;
      status  = ST_SEARCHING;
      foreach (cap[i]) cap[i] = '0;
    endfunction

    function void set_register(logic [7:0] idx, logic [7:0] val);
      case (idx)
        REG_MATCH_CLASS:    match_cls = val;
        REG_MATCH_SUBCLASS: match_sub = val;
        default: ;
      endcase
    endfunction

    // Decision at the last byte of a descriptor.
    function void decide_descriptor();
      bit typed;
      typed = dlen >= MIN_LEN_TYPED;
      case (mode)
        MODE_FIND_IF: begin
          if (typed && cap[0] == DESC_TYPE_INTERFACE && dlen >= MIN_LEN_INTERFACE &&
              cap[4] == match_cls && cap[5] == match_sub)
            mode = MODE_FIND_EP;
        end
        MODE_FIND_EP: begin
          if (typed && cap[0] == DESC_TYPE_ENDPOINT && dlen >= MIN_LEN_ENDPOINT &&
              cap[1][EP_DIR_IN_BIT] && cap[2][3:0] == {2'b00, XFER_TYPE_BULK}) begin
            ep   = cap[1][3:0];
            mps  = {cap[4], cap[3]};
            mode = MODE_CHECK_CS;
          end
        end
        MODE_CHECK_CS: begin
          if (typed && cap[0] == DESC_TYPE_CS_ENDPOINT && dlen >= MIN_LEN_CS_ENDPOINT &&
              cap[1] == CS_SUBTYPE_GENERAL) begin
            mode   = MODE_FOUND;
            status = ST_FOUND;
          end else begin
            mode = MODE_FIND_EP;
          end
        end
        default: ;
      endcase
    endfunction

    // Walk of the descriptor chain by length bytes.
    function void walk_descriptor(logic [7:0] b);
      if (pos == 0) begin
        if (b == 8'd0) begin
          status = ST_MALFORMED;
          return;
        end
        dlen = b;
        foreach (cap[i]) cap[i] = '0;
      end else if (pos <= CAPTURE_DEPTH) begin
        cap[pos - 1] = b;
      end
      if (({8'd0, pos} + 16'd1) >= {8'd0, dlen}) begin
        decide_descriptor();
        pos = '0;
      end else begin
        pos = pos + 8'd1;
      end
    endfunction

    // Notes one accepted input transaction and queues the result it causes.
    function void take_byte(logic [7:0] b, logic mark);
      result_t r;
      bit ended;
      if (mark) clear_scan();
      ended = status == ST_NO_MATCH || status == ST_MALFORMED ||
              (offset >= OFS_HEADER_END && offset >= total);
      if (!ended) begin
        if (offset == OFS_TOTAL_LO)        total[7:0]  = b;
        else if (offset == OFS_TOTAL_HI)   total[15:8] = b;
        else if (offset == OFS_CONFIG_VAL) cfg_val     = b;
        walk_descriptor(b);
        if (offset != OFS_MAX) offset = offset + 16'd1;
        if ((status == ST_SEARCHING || status == ST_FOUND) &&
            offset >= OFS_HEADER_END && offset >= total)
          status = (mode == MODE_FOUND) ? ST_FOUND : ST_NO_MATCH;
      end
      r.status  = status;
      r.ep      = (status == ST_FOUND) ? ep : 4'd0;
      r.mps     = (status == ST_FOUND) ? mps : 16'd0;
      r.cfg_val = cfg_val;
      pending_reports.push_back(r);
    endfunction

    function void report_mismatch(string field, int unsigned want, int unsigned got);
      failures++;
      $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compares one accepted result transaction with the oldest expectation.
    function void check_report(result_t got);
      result_t want;
      if (pending_reports.size() == 0) begin
        failures++;
        $display("%0t: result expected none, actual status %0d", $time, got.status);
        return;
      end
      want = pending_reports.pop_front();
      if (got.status !== want.status)   report_mismatch("scan_status", want.status, got.status);
      if (got.ep !== want.ep)           report_mismatch("endpoint_number", want.ep, got.ep);
      if (got.mps !== want.mps)         report_mismatch("max_packet_size", want.mps, got.mps);
      if (got.cfg_val !== want.cfg_val) report_mismatch("config_value", want.cfg_val, got.cfg_val);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic [7:0]  data_byte  = 8'd0;
  logic        first_byte = 1'b0;
  logic        out_ready  = 1'b0;
  logic        cfg_valid  = 1'b0;
  logic [7:0]  cfg_index  = 8'd0;
  logic [7:0]  cfg_data   = 8'd0;
  logic        in_ready;
  logic        out_valid;
  logic        cfg_ready;
  logic [1:0]  scan_status;
  logic [3:0]  endpoint_number;
  logic [15:0] max_packet_size;
  logic [7:0]  config_value;

  scan_scoreboard sb = new();
  bit             tx_quiet = 1'b0;
  bit             rx_quiet = 1'b0;
  int unsigned    bytes_sent = 0;
  logic [7:0]     set_bytes [$];

  usb_midi_descriptor_scanner_top dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .data_byte_i       (data_byte),
    .first_byte_i      (first_byte),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .scan_status_o     (scan_status),
    .endpoint_number_o (endpoint_number),
    .max_packet_size_o (max_packet_size),
    .config_value_o    (config_value),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #2000000;
    $display("tb_usb_midi_descriptor_scanner_top: done, errors");
    $finish;
  end

  function automatic int unsigned draw_wait(bit quiet);
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // Sends one byte as an input transaction after a random gap.
  task automatic send_byte(input logic [7:0] b, input logic mark);
    int unsigned gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    first_byte <= mark;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_byte(b, mark);
    bytes_sent++;
  endtask

  task automatic send_stream(input bit mark);
    int unsigned i;
    for (i = 0; i < set_bytes.size(); i++)
      send_byte(set_bytes[i], (i == 0) ? mark : 1'b0);
  endtask

  // Leaves the block idle with every expected result taken.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_reports.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_register(idx, val);
  endtask

  // Match settings per phase, extremes first; an unused index is written too.
  task automatic set_match(input int unsigned phase);
    logic [7:0] c;
    logic [7:0] s;
    case (phase % 5)
      0: begin c = 8'hFF; s = 8'hFF; end
      1: begin c = 8'h00; s = 8'h00; end
      2: begin c = MATCH_CLASS_RST; s = MATCH_SUBCLASS_RST; end
      default: begin c = 8'($urandom); s = 8'($urandom); end
    endcase
    write_reg(REG_MATCH_CLASS, c);
    write_reg(REG_MATCH_SUBCLASS, s);
    write_reg(8'($urandom_range(2, 255)), 8'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Appends one descriptor of the given kind, sometimes cut short or damaged.
  task automatic add_desc(input int kind);
    logic [7:0]  body [8];
    int unsigned len;
    int unsigned i;
    foreach (body[k]) body[k] = 8'($urandom);
    case (kind)
      KIND_HEADER: begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 12) : 9;
        body[0] = DESC_TYPE_CONFIG;
      end
      KIND_IF: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 9;
        if ($urandom_range(0, 15) != 0) body[0] = DESC_TYPE_INTERFACE;
        if ($urandom_range(0, 3) != 0)  body[4] = sb.match_cls;
        if ($urandom_range(0, 3) != 0)  body[5] = sb.match_sub;
      end
      KIND_EP: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) :
              (($urandom_range(0, 1) == 0) ? 7 : 9);
        if ($urandom_range(0, 15) != 0) body[0] = DESC_TYPE_ENDPOINT;
        if ($urandom_range(0, 4) != 0)  body[1][EP_DIR_IN_BIT] = 1'b1;
        if ($urandom_range(0, 4) != 0)  body[2][3:0] = {2'b00, XFER_TYPE_BULK};
      end
      KIND_CS: begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(3, 7);
        if ($urandom_range(0, 7) != 0) body[0] = DESC_TYPE_CS_ENDPOINT;
        if ($urandom_range(0, 4) != 0) body[1] = CS_SUBTYPE_GENERAL;
      end
      default: begin
        len = ($urandom_range(0, 39) == 0) ? 0 : $urandom_range(1, 12);
      end
    endcase
    set_bytes.push_back(8'(len));
    for (i = 1; i < len; i++)
      set_bytes.push_back((i <= 8) ? body[i - 1] : 8'($urandom));
  endtask

  // Builds a descriptor set: header, then groups that mostly follow the MIDI layout.
  task automatic build_set();
    int unsigned n;
    int unsigned pick;
    logic [15:0] total;
    set_bytes.delete();
    add_desc(KIND_HEADER);
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0) begin
        add_desc(KIND_IF);
        repeat ($urandom_range(1, 3)) begin
          if ($urandom_range(0, 3) == 0) add_desc(KIND_OTHER);
          add_desc(KIND_EP);
          add_desc(($urandom_range(0, 3) != 0) ? KIND_CS : KIND_OTHER);
        end
      end else begin
        repeat ($urandom_range(1, 3)) add_desc($urandom_range(KIND_IF, KIND_OTHER));
      end
    end
    while (set_bytes.size() < 6) set_bytes.push_back(8'($urandom));
    n = set_bytes.size();
    // Exact length mostly; otherwise cut a descriptor, overrun, tiny or arbitrary.
    pick = $urandom_range(0, 19);
    if (pick < 12)      total = 16'(n);
    else if (pick < 15) total = 16'(n - $urandom_range(1, (n < 10) ? n : 10));
    else if (pick < 17) total = 16'(n + $urandom_range(1, 20));
    else if (pick < 19) total = 16'($urandom_range(0, 6));
    else                total = 16'($urandom);
    set_bytes[2] = total[7:0];
    set_bytes[3] = total[15:8];
    // Bytes past the end of the set.
    if ($urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 6)) set_bytes.push_back(8'($urandom));
  endtask

  // Result side: random stalls, then every result transaction is checked.
  initial begin
    int unsigned stall;
    int unsigned taken;
    result_t     seen;
    taken = 0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (taken % 32 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      stall = draw_wait(rx_quiet);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      seen.status  = status_e'(scan_status);
      seen.ep      = endpoint_number;
      seen.mps     = max_packet_size;
      seen.cfg_val = config_value;
      sb.check_report(seen);
      taken++;
    end
  end

  // Main sequence: reset, directed sets, then random phases.
  initial begin
    int unsigned sets;
    int unsigned i;
    int unsigned directed;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Byte zero without the mark after reset; a total of four ends after byte three.
    set_bytes = '{8'd9, DESC_TYPE_CONFIG, 8'd4, 8'd0};
    send_stream(1'b0);
    // Shortest full match, found early, then a length-one descriptor closes the set.
    set_bytes = '{8'd4, DESC_TYPE_CONFIG, 8'd21, 8'd0,
                  8'd7, DESC_TYPE_INTERFACE, 8'd0, 8'd0, 8'd0,
                  MATCH_CLASS_RST, MATCH_SUBCLASS_RST,
                  8'd6, DESC_TYPE_ENDPOINT, 8'h8F, 8'h02, 8'hFF, 8'hFF,
                  8'd3, DESC_TYPE_CS_ENDPOINT, CS_SUBTYPE_GENERAL,
                  8'd1};
    send_stream(1'b1);
    // Zero length at the very first descriptor.
    set_bytes = '{8'd0};
    send_stream(1'b1);
    directed = bytes_sent;

    sets = 0;
    while (bytes_sent < directed + RANDOM_ITEMS) begin
      if (sets % 5 == 0) begin
        settle();
        set_match(sets / 5);
      end
      tx_quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) begin
        // Noise: random bytes with random restart marks.
        repeat ($urandom_range(4, 24))
          send_byte(8'($urandom), ($urandom_range(0, 5) == 0));
      end else begin
        build_set();
        send_stream($urandom_range(0, 15) != 0);
      end
      sets++;
    end

    settle();
    repeat (4) @(posedge clk);
    if (sb.failures == 0 && sb.pending_reports.size() == 0) begin
      $display("tb_usb_midi_descriptor_scanner_top: done, clean");
    end else begin
      $display("tb_usb_midi_descriptor_scanner_top: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/umds_pkg.sv
hdl/umds_walk.sv
hdl/umds_out_stage.sv
hdl/usb_midi_descriptor_scanner_top.sv
hdl/umds_checker.sv
verif/tb_usb_midi_descriptor_scanner_top.sv
